// ===== hdl/pps_pkg.sv =====
// shared types, codes and constants of the preemptive priority scheduler
package pps_pkg;

	localparam int MAX_PROCS_DEF = 16;

	localparam int ID_W    = 16;
	localparam int PRIO_W  = 8;
	localparam int TIME_W  = 16;
	localparam int SLOT_IN_W = 4;
	localparam int PCNT_W  = 5;
	localparam int SWT_W   = 8;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_TIME   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [SLOT_IN_W-1:0] slot;
		logic [ID_W-1:0]      proc_id;
		logic [PRIO_W-1:0]    priority_req;
		logic [TIME_W-1:0]    born_time;
		logic [TIME_W-1:0]    cpu_time;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        switching;
		logic        ran;
		logic [15:0] running_id;
		logic        finished;
		logic [31:0] sim_time;
		logic [15:0] switch_count;
		logic [31:0] overhead_ticks;
		logic [47:0] total_turnaround;
	} rsp_t;

	// one table entry held by a cell
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] remaining;
	} entry_t;

	// best candidate seen so far on the scan chain
	typedef struct packed {
		logic              found;
		logic [PRIO_W-1:0] prio;
		logic [ID_W-1:0]   id;
	} cand_t;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic                 wr_en;
		logic [SLOT_IN_W-1:0] wr_slot;
		logic                 dec;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RUN,
		ST_ACCUM
	} pps_state_t;

endpackage

// ===== hdl/pps_cell.sv =====
// one scheduler cell: a table entry plus one stage of the candidate scan chain
module pps_cell #(
	parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
	parameter int IDX       = 0,
	parameter int SLOT_W    = $clog2(MAX_PROCS) + 1,
	parameter int CNT_W     = $clog2(MAX_PROCS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pps_pkg::cell_ctl_t ctl,
	input  pps_pkg::entry_t   wr_entry,
	input  logic [SLOT_W-1:0] sel,
	input  logic [CNT_W-1:0]  n,
	input  logic [31:0]       t,
	input  logic              tok_vld_in,
	input  pps_pkg::cand_t    tok_in,
	input  logic [SLOT_W-1:0] tok_slot_in,
	output logic              tok_vld_out,
	output pps_pkg::cand_t    tok_out,
	output logic [SLOT_W-1:0] tok_slot_out,
	output pps_pkg::entry_t   rd
);
	import pps_pkg::*;

	entry_t            entry_q;
	logic              vld_q;
	cand_t             cand_q;
	logic [SLOT_W-1:0] slot_q;
	logic              hit;
	logic              elig;
	logic              better;
	logic              take;

	assign hit = (sel == SLOT_W'(IDX));
	assign rd  = hit ? entry_q : '0;

	// entry storage: loads and one-unit decrements
	always_ff @(posedge clk) begin
		if (ctl.wr_en && (32'(ctl.wr_slot) == 32'(IDX))) begin
			entry_q <= wr_entry;
		end else if (ctl.dec && hit) begin
			entry_q.remaining <= entry_q.remaining - 16'd1;
		end
	end

	always_comb begin
		elig   = (32'(n) > 32'(IDX)) && ({16'd0, entry_q.arrival} <= t) &&
			(entry_q.remaining != '0);
		better = !tok_in.found || (entry_q.prio < tok_in.prio) ||
			((entry_q.prio == tok_in.prio) && (entry_q.id < tok_in.id));
		take   = elig && better;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cand_q <= '{found: 1'b1, prio: entry_q.prio, id: entry_q.id};
			slot_q <= SLOT_W'(IDX);
		end else begin
			cand_q <= tok_in;
			slot_q <= tok_slot_in;
		end
	end

	assign tok_vld_out  = vld_q;
	assign tok_out      = cand_q;
	assign tok_slot_out = slot_q;

endmodule

// ===== hdl/preemptive_priority_scheduler.sv =====
// preemptive priority scheduler: sequencer, counters and the chain of table cells
//
// command channel: an item is transferred on a rising edge with start high and busy low.
//   a load writes one table slot and is answered in the next cycle; loads may follow
//   each other in every cycle.
//   a tick runs a candidate scan through the chain of MAX_PROCS cells, one cell per
//   cycle, with the switch decision taken as the token leaves the last cell, then a run
//   cycle and an accumulate cycle; its result is registered in the accumulate cycle and
//   the next item can be transferred in the strobe cycle.
//   the scan chain dominates a tick: one comparator per cell, one cell per cycle.
//   a tick with every loaded process finished is answered in the next cycle (kind done).
// result channel: rsp is valid for exactly one cycle while rsp_strobe is high; the
//   receiver cannot hold it off and there is no stall path.
// configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is the
//   switch time, index 1 the process count; write only while idle.
// reset: arst_n clears the sequencer, counters, time, switch state and registers;
//   table entries hold whatever until loaded.
module preemptive_priority_scheduler #(
	parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  pps_pkg::req_t                     req,
	output logic                              rsp_strobe,
	output pps_pkg::rsp_t                     rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pps_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pps_pkg::*;

	localparam int SLOT_W = $clog2(MAX_PROCS) + 1;
	localparam int CNT_W  = $clog2(MAX_PROCS + 1);
	localparam logic [SLOT_W-1:0] NONE_SLOT = '1;

	// sequencer
	pps_state_t state_q, state_d;

	// configuration
	logic [SWT_W-1:0]  switch_time_q;
	logic [PCNT_W-1:0] process_count_q;

	// scheduling state
	logic [SLOT_W-1:0] cur_q;
	logic [SLOT_W-1:0] pend_q;
	logic [SWT_W-1:0]  switch_left_q;
	logic [31:0]       tick_time_q;
	logic [4:0]        fin_count_q;
	logic [15:0]       switches_q;
	logic [31:0]       overhead_q;
	logic [47:0]       turnaround_q;

	// per-tick working registers
	logic        sw_q;
	logic        ran_q;
	logic [15:0] rid_q;
	logic        fin_q;
	logic [32:0] ta_q;

	// result register
	logic strobe_q;
	rsp_t rsp_q;

	// chain wiring
	logic              tok_vld [MAX_PROCS+1];
	cand_t             tok     [MAX_PROCS+1];
	logic [SLOT_W-1:0] tok_slot[MAX_PROCS+1];
	entry_t            rd_w    [MAX_PROCS];
	entry_t            rd_any;

	cell_ctl_t  ctl;
	entry_t     wr_entry;
	logic [CNT_W-1:0] n_eff;
	logic       accept;
	logic       all_done;
	logic       inject;
	logic       scan_end;
	logic       run_ok;

	// decision values at the end of the scan
	logic [SLOT_W-1:0] best;
	logic [SLOT_W-1:0] d_cur;
	logic [SLOT_W-1:0] d_pend;
	logic [SWT_W-1:0]  d_sl;
	logic              d_sw;
	logic              d_new_switch;

	logic [33:0] ta_diff;
	logic [48:0] sum_next;
	logic [47:0] turnaround_next;

	// process count clamps at the table size
	assign n_eff = (32'(process_count_q) > 32'(MAX_PROCS)) ? CNT_W'(MAX_PROCS) :
		CNT_W'(process_count_q);

	assign accept   = start && !busy;
	assign all_done = (32'(fin_count_q) >= 32'(n_eff));
	assign scan_end = tok_vld[MAX_PROCS];
	assign cfg_ready = 1'b1;

	assign wr_entry = '{id: req.proc_id, prio: req.priority_req, arrival: req.born_time,
		remaining: req.cpu_time};

	// next state and broadcast controls
	always_comb begin
		state_d     = state_q;
		busy        = 1'b1;
		inject      = 1'b0;
		ctl.wr_en   = 1'b0;
		ctl.wr_slot = req.slot;
		ctl.dec     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (req.req_type == REQ_LOAD) begin
						ctl.wr_en = 1'b1;
					end else if (!all_done) begin
						inject  = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				ctl.dec = run_ok;
				state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan chain: token enters cell 0 and ripples one cell per cycle
	assign tok_vld[0]  = inject;
	assign tok[0]      = '0;
	assign tok_slot[0] = NONE_SLOT;

	for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
		pps_cell #(
			.MAX_PROCS(MAX_PROCS),
			.IDX      (i),
			.SLOT_W   (SLOT_W),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.wr_entry    (wr_entry),
			.sel         (cur_q),
			.n           (n_eff),
			.t           (tick_time_q),
			.tok_vld_in  (tok_vld[i]),
			.tok_in      (tok[i]),
			.tok_slot_in (tok_slot[i]),
			.tok_vld_out (tok_vld[i+1]),
			.tok_out     (tok[i+1]),
			.tok_slot_out(tok_slot[i+1]),
			.rd          (rd_w[i])
		);
	end

	// only the selected cell drives a nonzero entry
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < MAX_PROCS; i++) begin
			rd_any = rd_any | rd_w[i];
		end
	end

	// switch decision once the token leaves the last cell
	always_comb begin
		best         = tok[MAX_PROCS].found ? tok_slot[MAX_PROCS] : NONE_SLOT;
		d_cur        = cur_q;
		d_pend       = pend_q;
		d_sl         = switch_left_q;
		d_sw         = 1'b0;
		d_new_switch = 1'b0;
		if (switch_left_q != '0) begin
			// switch in progress: burn one overhead tick
			d_sw = 1'b1;
			d_sl = switch_left_q - 8'd1;
			if (d_sl == '0) begin
				d_cur  = pend_q;
				d_pend = NONE_SLOT;
			end
		end else if (best != cur_q) begin
			if ((switch_time_q != '0) && (best != NONE_SLOT)) begin
				d_sw         = 1'b1;
				d_new_switch = 1'b1;
				d_sl         = switch_time_q - 8'd1;
				if (d_sl == '0) begin
					d_cur  = best;
					d_pend = NONE_SLOT;
				end else begin
					d_cur  = NONE_SLOT;
					d_pend = best;
				end
			end else begin
				// instant hand-over
				d_cur = best;
			end
		end
	end

	// run cycle: the selected process executes when no switch is pending and it has time left
	assign run_ok  = (switch_left_q == '0) && (cur_q != NONE_SLOT) &&
		(rd_any.remaining != '0);
	assign ta_diff = {2'b00, tick_time_q} + 34'd1 - {18'd0, rd_any.arrival};

	// accumulate cycle: saturating turnaround sum
	assign sum_next        = {1'b0, turnaround_q} + 49'(ta_q);
	assign turnaround_next = sum_next[48] ? '1 : sum_next[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_time_q   <= '0;
			process_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SWITCH_TIME:   switch_time_q   <= cfg_data;
				CFG_PROCESS_COUNT: process_count_q <= cfg_data[PCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q         <= NONE_SLOT;
			pend_q        <= NONE_SLOT;
			switch_left_q <= '0;
			tick_time_q   <= '0;
			fin_count_q   <= '0;
			switches_q    <= '0;
			overhead_q    <= '0;
			turnaround_q  <= '0;
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && ((req.req_type == REQ_LOAD) || all_done)) begin
						strobe_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						cur_q         <= d_cur;
						pend_q        <= d_pend;
						switch_left_q <= d_sl;
						if (d_sw && (overhead_q != '1)) begin
							overhead_q <= overhead_q + 32'd1;
						end
						if (d_new_switch && (switches_q != '1)) begin
							switches_q <= switches_q + 16'd1;
						end
					end
				end
				ST_RUN: begin
					if (run_ok && (rd_any.remaining == 16'd1)) begin
						cur_q <= NONE_SLOT;
						if (fin_count_q != '1) begin
							fin_count_q <= fin_count_q + 5'd1;
						end
					end
				end
				ST_ACCUM: begin
					turnaround_q <= turnaround_next;
					tick_time_q  <= tick_time_q + 32'd1;
					strobe_q     <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// per-tick payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && scan_end) begin
			sw_q <= d_sw;
		end
		if (state_q == ST_RUN) begin
			ran_q <= run_ok;
			rid_q <= run_ok ? rd_any.id : '0;
			fin_q <= run_ok && (rd_any.remaining == 16'd1);
			// negative turnaround adds nothing
			ta_q  <= (run_ok && (rd_any.remaining == 16'd1) && !ta_diff[33]) ?
				ta_diff[32:0] : '0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			rsp_q.kind             <= (req.req_type == REQ_LOAD) ? KIND_LOAD : KIND_DONE;
			rsp_q.switching        <= 1'b0;
			rsp_q.ran              <= 1'b0;
			rsp_q.running_id       <= '0;
			rsp_q.finished         <= 1'b0;
			rsp_q.sim_time         <= tick_time_q;
			rsp_q.switch_count     <= switches_q;
			rsp_q.overhead_ticks   <= overhead_q;
			rsp_q.total_turnaround <= turnaround_q;
		end else if (state_q == ST_ACCUM) begin
			rsp_q.kind             <= KIND_TICK;
			rsp_q.switching        <= sw_q;
			rsp_q.ran              <= ran_q;
			rsp_q.running_id       <= rid_q;
			rsp_q.finished         <= fin_q;
			rsp_q.sim_time         <= tick_time_q;
			rsp_q.switch_count     <= switches_q;
			rsp_q.overhead_ticks   <= overhead_q;
			rsp_q.total_turnaround <= turnaround_next;
		end
	end

	assign rsp_strobe = strobe_q;
	assign rsp        = rsp_q;

`ifndef ASSERT_OFF
	// the scan token only leaves the chain while the sequencer waits for it
	a_scan_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_end |-> (state_q == ST_SCAN))
		else $error("scan token left the chain outside the scan phase");

	// a switch in progress always has a target
	a_switch_target: assert property (@(posedge clk) disable iff (!arst_n)
		(switch_left_q != '0) |-> (pend_q != NONE_SLOT))
		else $error("switch in progress without a pending target");

	// a finishing tick must have run a process
	a_finish_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_strobe && rsp.finished) |-> rsp.ran)
		else $error("finished reported without a running process");

	// the finished count never goes backwards
	a_fin_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_count_q != $past(fin_count_q)) |-> (fin_count_q == $past(fin_count_q) + 5'd1))
		else $error("finished count changed by other than one");
`endif

endmodule
